// ===== rtl/core/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunk reassembly tracker package
// Shared types, constants and state codes of the chunk reassembly tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int MAX_MESSAGES = 16;
    localparam int MAX_CHUNKS   = 64;
    localparam int SLOT_W       = $clog2(MAX_MESSAGES);
    localparam int IDX_W        = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W        = 7;

    localparam logic [15:0] MIN_PACKET    = 16'd13;
    localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

    localparam logic [2:0] KIND_PARTIAL = 3'd0;
    localparam logic [2:0] KIND_DONE    = 3'd1;
    localparam logic [2:0] KIND_SHORT   = 3'd2;
    localparam logic [2:0] KIND_BADCNT  = 3'd3;
    localparam logic [2:0] KIND_BADIDX  = 3'd4;
    localparam logic [2:0] KIND_BEYOND  = 3'd5;
    localparam logic [2:0] KIND_FULL    = 3'd6;
    localparam logic [2:0] KIND_EVICT   = 3'd7;

    typedef struct packed {
        logic        cmd;
        logic [15:0] packet_length;
        logic        is_multi;
        logic [31:0] message_id;
        logic [31:0] chunk_count;
        logic [31:0] chunk_index;
    } crt_in_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [31:0]      result_id;
        logic [3:0]       slot;
        logic [CNT_W-1:0] chunks_received;
        logic [CNT_W-1:0] chunks_total;
        logic             last;
    } crt_out_t;

    typedef struct packed {
        logic [31:0]           id;
        logic [CNT_W-1:0]      total;
        logic [CNT_W-1:0]      received;
        logic [MAX_CHUNKS-1:0] bitmap;
        logic [31:0]           stamp;
    } crt_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        crt_entry_t        data;
    } crt_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_UPD,
        ST_SW_RD,
        ST_SW_CHK,
        ST_FLUSH
    } crt_state_t;

endpackage

// ===== rtl/core/chunk_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// Chunk reassembly tracker
// Matches chunk headers to table slots, reports completion and evicts
// stale messages.
// ----------------------------------------------------------------------------
// A tick item only advances the tick counter. A chunk item has its header
// checked first; a rejected header goes to output, and the id search reads
// one table slot per cycle from the single read port of the table.
// A sweep reads, then checks, each slot; an eviction waits for free output.
// Reset clears the valid bits, tick counter and sweep mark at once and loads
// the timeout with 60000; the table memory itself is not cleared.
module chunk_reassembly_tracker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  crt_pkg::crt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output crt_pkg::crt_out_t m_data,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata
);
    import crt_pkg::*;

    crt_state_t state_reg, state_next;
    logic [31:0] timeout_reg, timeout_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] last_sweep_reg, last_sweep_next;
    logic [MAX_MESSAGES-1:0] valid_reg, valid_next;
    logic [31:0] id_reg, id_next;
    logic [CNT_W-1:0] tot_reg, tot_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SLOT_W:0] scan_reg, scan_next;
    logic chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0] chk_slot_reg, chk_slot_next;
    logic found_reg, found_next;
    logic [SLOT_W-1:0] fslot_reg, fslot_next;
    logic [SLOT_W-1:0] sw_reg, sw_next;
    crt_out_t pend_reg, pend_next;
    crt_out_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    crt_wr_t wr;
    logic rd_en;
    logic [SLOT_W-1:0] rd_addr;
    crt_entry_t rd;

    logic s_acc, out_free, push, push_last;
    logic [31:0] dec_id, dec_cnt, dec_idx;
    logic early;
    logic hit, scan_done, beyond, sweep_due, stale, complete, has_free;
    logic [SLOT_W-1:0] free_slot;
    logic [CNT_W-1:0] u_tot, u_rcv, u_rcv2;
    logic [MAX_CHUNKS-1:0] u_bm, u_bm2, u_bit;

    crt_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign dec_id  = s_data.is_multi ? s_data.message_id  : 32'd0;
    assign dec_cnt = s_data.is_multi ? s_data.chunk_count : 32'd1;
    assign dec_idx = s_data.is_multi ? s_data.chunk_index : 32'd0;
    assign early   = (s_data.packet_length < MIN_PACKET) ||
                     (dec_cnt > 32'(MAX_CHUNKS)) || (dec_idx >= dec_cnt);

    assign hit       = chk_valid_reg && valid_reg[chk_slot_reg] && (rd.id == id_reg);
    assign scan_done = chk_valid_reg && (chk_slot_reg == SLOT_W'(MAX_MESSAGES - 1));

    assign u_tot  = found_reg ? rd.total : tot_reg;
    assign u_rcv  = found_reg ? rd.received : '0;
    assign u_bm   = found_reg ? rd.bitmap : '0;
    assign u_bit  = MAX_CHUNKS'(1) << idx_reg;
    assign u_bm2  = u_bm | u_bit;
    assign u_rcv2 = u_rcv + CNT_W'((u_bm & u_bit) == '0);
    assign beyond   = found_reg && ({{(CNT_W - IDX_W){1'b0}}, idx_reg} >= u_tot);
    assign complete = (u_rcv2 == u_tot);

    assign sweep_due = (tick_reg - last_sweep_reg) >= timeout_reg;
    assign stale     = valid_reg[sw_reg] && ((tick_reg - rd.stamp) > timeout_reg);

    always_comb begin
        has_free  = 1'b0;
        free_slot = '0;
        for (int s = MAX_MESSAGES - 1; s >= 0; s--) begin
            if (!valid_reg[s]) begin
                has_free  = 1'b1;
                free_slot = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && !s_data.cmd) begin
                    state_next = early ? ST_FLUSH : ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (hit || scan_done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = (!beyond && sweep_due) ? ST_SW_RD : ST_FLUSH;
            end
            ST_SW_RD: begin
                state_next = ST_SW_CHK;
            end
            ST_SW_CHK: begin
                if (!stale || out_free) begin
                    state_next = (sw_reg == SLOT_W'(MAX_MESSAGES - 1)) ? ST_FLUSH : ST_SW_RD;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        timeout_next    = cfg_we ? cfg_wdata : timeout_reg;
        tick_next       = tick_reg;
        last_sweep_next = last_sweep_reg;
        valid_next      = valid_reg;
        id_next         = id_reg;
        tot_next        = tot_reg;
        idx_next        = idx_reg;
        scan_next       = scan_reg;
        chk_valid_next  = 1'b0;
        chk_slot_next   = chk_slot_reg;
        found_next      = found_reg;
        fslot_next      = fslot_reg;
        sw_next         = sw_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = sw_reg;
        wr              = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_data.cmd) begin
                        tick_next = tick_reg + 32'd1;
                    end else begin
                        id_next    = dec_id;
                        tot_next   = CNT_W'(dec_cnt);
                        idx_next   = IDX_W'(dec_idx);
                        scan_next  = '0;
                        found_next = 1'b0;
                        pend_next  = '0;
                        if (s_data.packet_length < MIN_PACKET) begin
                            pend_next.kind = KIND_SHORT;
                        end else if (dec_cnt > 32'(MAX_CHUNKS)) begin
                            pend_next.kind      = KIND_BADCNT;
                            pend_next.result_id = dec_id;
                        end else begin
                            pend_next.kind         = KIND_BADIDX;
                            pend_next.result_id    = dec_id;
                            pend_next.chunks_total = CNT_W'(dec_cnt);
                        end
                    end
                end
            end
            ST_SRCH: begin
                rd_en   = !scan_reg[SLOT_W] && !hit;
                rd_addr = scan_reg[SLOT_W-1:0];
                if (rd_en) begin
                    scan_next      = scan_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_slot_next  = scan_reg[SLOT_W-1:0];
                end
                if (hit) begin
                    found_next = 1'b1;
                    fslot_next = chk_slot_reg;
                end
            end
            ST_UPD: begin
                pend_next.result_id       = id_reg;
                pend_next.chunks_received = u_rcv2;
                pend_next.chunks_total    = u_tot;
                pend_next.last            = 1'b0;
                pend_next.slot            = '0;
                wr.data.id       = id_reg;
                wr.data.total    = u_tot;
                wr.data.received = u_rcv2;
                wr.data.bitmap   = u_bm2;
                wr.data.stamp    = tick_reg;
                if (beyond) begin
                    pend_next.kind            = KIND_BEYOND;
                    pend_next.slot            = 4'(fslot_reg);
                    pend_next.chunks_received = u_rcv;
                end else if (complete) begin
                    pend_next.kind = KIND_DONE;
                    if (found_reg) begin
                        pend_next.slot        = 4'(fslot_reg);
                        valid_next[fslot_reg] = 1'b0;
                    end
                end else if (found_reg) begin
                    pend_next.kind = KIND_PARTIAL;
                    pend_next.slot = 4'(fslot_reg);
                    wr.en          = 1'b1;
                    wr.addr        = fslot_reg;
                end else if (has_free) begin
                    pend_next.kind        = KIND_PARTIAL;
                    pend_next.slot        = 4'(free_slot);
                    wr.en                 = 1'b1;
                    wr.addr               = free_slot;
                    valid_next[free_slot] = 1'b1;
                end else begin
                    pend_next.kind = KIND_FULL;
                end
                if (!beyond && sweep_due) begin
                    last_sweep_next = tick_reg;
                    sw_next         = '0;
                end
            end
            ST_SW_RD: begin
                rd_en   = 1'b1;
                rd_addr = sw_reg;
            end
            ST_SW_CHK: begin
                if (!stale || out_free) begin
                    sw_next = sw_reg + 1'b1;
                end
                if (stale && out_free) begin
                    push                      = 1'b1;
                    valid_next[sw_reg]        = 1'b0;
                    pend_next.kind            = KIND_EVICT;
                    pend_next.result_id       = rd.id;
                    pend_next.slot            = 4'(sw_reg);
                    pend_next.chunks_received = rd.received;
                    pend_next.chunks_total    = rd.total;
                    pend_next.last            = 1'b0;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase

        out_next = out_reg;
        if (push) begin
            out_next      = pend_reg;
            out_next.last = push_last;
        end
        if (push) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            timeout_reg    <= TIMEOUT_RESET;
            tick_reg       <= '0;
            last_sweep_reg <= '0;
            valid_reg      <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            timeout_reg    <= timeout_next;
            tick_reg       <= tick_next;
            last_sweep_reg <= last_sweep_next;
            valid_reg      <= valid_next;
            chk_valid_reg  <= chk_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        tot_reg      <= tot_next;
        idx_reg      <= idx_next;
        scan_reg     <= scan_next;
        chk_slot_reg <= chk_slot_next;
        found_reg    <= found_next;
        fslot_reg    <= fslot_next;
        sw_reg       <= sw_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    a_last_from_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_last) |-> (state_reg == ST_FLUSH))
        else $error("final item pushed outside flush");

    a_no_read_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRCH && hit) |-> !rd_en)
        else $error("table read issued after a hit");

    a_alloc_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && wr.en && !found_reg) |-> !valid_reg[wr.addr])
        else $error("allocation into an occupied slot");

endmodule

// ===== rtl/core/crt_table.sv =====
// ----------------------------------------------------------------------------
// Chunk reassembly table memory
// One write port and one enabled read port with registered read data.
// ----------------------------------------------------------------------------
module crt_table (
    input  logic                             aclk,
    input  crt_pkg::crt_wr_t                 wr,
    input  logic                             rd_en,
    input  logic [crt_pkg::SLOT_W-1:0]       rd_addr,
    output crt_pkg::crt_entry_t              rd_data
);
    import crt_pkg::*;

    crt_entry_t mem [MAX_MESSAGES];
    crt_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/sv/chunk_reassembly_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// Chunk reassembly tracker testbench
// Drives chunk and tick items with random gaps and output stalls. A scoreboard
// keeps its own copy of the slot table and checks each result in order.
// ----------------------------------------------------------------------------
module chunk_reassembly_tracker_tb;
    import crt_pkg::*;

    localparam int LIMIT = 600000;
    localparam int IN_W  = $bits(crt_in_t);

    class crt_scoreboard;
        logic [31:0] timeout;
        bit          busy[MAX_MESSAGES];
        logic [31:0] ids[MAX_MESSAGES];
        logic [6:0]  totals[MAX_MESSAGES];
        logic [6:0]  counts[MAX_MESSAGES];
        logic [63:0] seen[MAX_MESSAGES];
        logic [31:0] stamps[MAX_MESSAGES];
        logic [31:0] now;
        logic [31:0] swept;
        crt_out_t    pending[$];
        int          errors;

        function new();
            timeout = TIMEOUT_RESET;
            foreach (busy[i]) busy[i] = 0;
            now = 0;
            swept = 0;
            errors = 0;
        endfunction

        function void add(logic [2:0] kind, logic [31:0] id, int slot,
                          logic [6:0] r, logic [6:0] t);
            crt_out_t e;
            e.kind = kind;
            e.result_id = id;
            e.slot = slot[3:0];
            e.chunks_received = r;
            e.chunks_total = t;
            e.last = 1'b0;
            pending.push_back(e);
        endfunction

        function void note_input(crt_in_t x);
            logic [31:0] id, cnt, idx;
            logic [6:0]  tot, rcv;
            logic [63:0] bits;
            crt_out_t    e;
            int          found, free;
            found = -1;
            free = -1;
            if (x.cmd) begin
                now = now + 1;
                return;
            end
            if (x.packet_length < MIN_PACKET) begin
                add(KIND_SHORT, 0, 0, 0, 0);
            end else begin
                if (x.is_multi) begin
                    id = x.message_id;
                    cnt = x.chunk_count;
                    idx = x.chunk_index;
                end else begin
                    id = 0;
                    cnt = 1;
                    idx = 0;
                end
                if (cnt > MAX_CHUNKS) begin
                    add(KIND_BADCNT, id, 0, 0, 0);
                end else if (idx >= cnt) begin
                    add(KIND_BADIDX, id, 0, 0, cnt[6:0]);
                end else begin
                    for (int s = 0; s < MAX_MESSAGES; s++)
                        if (found < 0 && busy[s] && ids[s] == id) found = s;
                    if (found >= 0 && idx >= totals[found]) begin
                        add(KIND_BEYOND, id, found, counts[found], totals[found]);
                    end else begin
                        if (found >= 0) begin
                            tot = totals[found];
                            rcv = counts[found];
                            bits = seen[found];
                        end else begin
                            tot = cnt[6:0];
                            rcv = 0;
                            bits = 0;
                        end
                        if (!bits[idx[5:0]]) begin
                            bits[idx[5:0]] = 1'b1;
                            rcv = rcv + 7'd1;
                        end
                        if (rcv == tot) begin
                            if (found >= 0) busy[found] = 0;
                            add(KIND_DONE, id, (found >= 0) ? found : 0, rcv, tot);
                        end else if (found >= 0) begin
                            counts[found] = rcv;
                            seen[found] = bits;
                            stamps[found] = now;
                            add(KIND_PARTIAL, id, found, rcv, tot);
                        end else begin
                            for (int s = 0; s < MAX_MESSAGES; s++)
                                if (free < 0 && !busy[s]) free = s;
                            if (free >= 0) begin
                                busy[free] = 1;
                                ids[free] = id;
                                totals[free] = tot;
                                counts[free] = rcv;
                                seen[free] = bits;
                                stamps[free] = now;
                                add(KIND_PARTIAL, id, free, rcv, tot);
                            end else begin
                                add(KIND_FULL, id, 0, rcv, tot);
                            end
                        end
                        if (now - swept >= timeout) begin
                            swept = now;
                            for (int s = 0; s < MAX_MESSAGES; s++) begin
                                if (busy[s] && (now - stamps[s]) > timeout) begin
                                    busy[s] = 0;
                                    add(KIND_EVICT, ids[s], s, counts[s], totals[s]);
                                end
                            end
                        end
                    end
                end
            end
            e = pending.pop_back();
            e.last = 1'b1;
            pending.push_back(e);
        endfunction

        function void check_result(crt_out_t got);
            crt_out_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    crt_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    crt_out_t m_data;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    crt_scoreboard tracker_sb;
    int            cycles;
    logic [31:0]   pool_id[24];
    logic [31:0]   pool_cnt[24];

    chunk_reassembly_tracker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("chunk_reassembly_tracker regression: fail");
            $finish;
        end
    end

    task automatic send_item(crt_in_t x);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= x;
        do @(posedge aclk); while (!s_ready);
        tracker_sb.note_input(x);
    endtask

    task automatic send_chunk(logic [15:0] len, logic multi, logic [31:0] id,
                              logic [31:0] cnt, logic [31:0] idx);
        crt_in_t x;
        x.cmd = 1'b0;
        x.packet_length = len;
        x.is_multi = multi;
        x.message_id = id;
        x.chunk_count = cnt;
        x.chunk_index = idx;
        send_item(x);
    endtask

    task automatic send_tick();
        crt_in_t x;
        x = crt_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
        x.cmd = 1'b1;
        send_item(x);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker_sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        drain();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        tracker_sb.timeout = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random();
        int pick, p;
        crt_in_t x;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_tick();
        end else if (pick < 25) begin
            x = crt_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
            x.cmd = 1'b0;
            if (pick < 19) x.chunk_count = $urandom_range(0, 70);
            if (pick < 17) x.chunk_index = $urandom_range(0, 70);
            send_item(x);
        end else begin
            p = $urandom_range(0, 23);
            if ($urandom_range(0, 29) == 0) begin
                pool_id[p] = $urandom;
                pool_cnt[p] = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 8);
            end
            send_chunk(16'($urandom_range(13, 65535)), 1'b1, pool_id[p],
                       ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : pool_cnt[p],
                       $urandom_range(0, pool_cnt[p] - 1));
        end
    endtask

    initial begin
        aclk = 1'b0;
        m_ready = 1'b0;
        forever begin
            repeat ($urandom_range(0, 3)) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
            tracker_sb.check_result(m_data);
        end
    end

    initial begin
        logic [31:0] settings[5];
        tracker_sb = new();
        cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        foreach (pool_id[i]) begin
            pool_id[i] = $urandom;
            pool_cnt[i] = (i % 6 == 0) ? 64 : $urandom_range(1, 8);
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_chunk(0, 1'b1, 32'h1, 2, 0);
        send_chunk(12, 1'b1, 32'h2, 2, 0);
        send_chunk(13, 1'b0, $urandom, $urandom, $urandom);
        send_chunk(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 65, 0);
        send_chunk(20, 1'b1, 32'h5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_chunk(20, 1'b1, 32'h6, 0, 0);
        send_chunk(20, 1'b1, 32'h7, 4, 4);
        send_chunk(20, 1'b1, 32'hA, 3, 0);
        send_chunk(20, 1'b1, 32'hA, 3, 0);
        send_chunk(20, 1'b1, 32'hA, 5, 2);
        send_chunk(20, 1'b1, 32'hA, 5, 4);
        send_chunk(20, 1'b1, 32'hB, 64, 63);
        send_tick();
        send_chunk(20, 1'b1, 32'hA, 3, 1);
        send_chunk(20, 1'b1, 32'hC, 1, 0);
        write_timeout(0);
        send_tick();
        send_tick();
        send_chunk(20, 1'b1, 32'hD, 2, 0);
        send_chunk(20, 1'b1, 32'hD, 2, 0);
        write_timeout(32'hFFFF_FFFF);
        send_chunk(20, 1'b1, 32'hE, 2, 1);

        settings = '{TIMEOUT_RESET, 32'd3, 32'd0, 32'd12, 32'hFFFF_FFFF};
        foreach (settings[k]) begin
            write_timeout(settings[k]);
            repeat (86) send_random();
        end

        drain();
        if (tracker_sb.errors == 0 && tracker_sb.pending.size() == 0) begin
            $display("chunk_reassembly_tracker regression: pass");
        end else begin
            $display("chunk_reassembly_tracker regression: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/crt_pkg.sv
rtl/core/crt_table.sv
rtl/core/chunk_reassembly_tracker.sv
tb/sv/chunk_reassembly_tracker_tb.sv
